### rtl/round_robin_thread_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin thread scheduler
// Clocked concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_TOP_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_TOP_ASSERT_SVH

// assertion checked outside reset
`define RRTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion checked on every edge, reset included
`define RRTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int THREAD_W = 6;
  localparam int MASK_W   = 32;
  localparam int TICK_W   = 32;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_DELAY = 2'd2;
  localparam logic [1:0] ACT_SCHED = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [TICK_W-1:0] ticks;
  } in_t;

  typedef struct packed {
    logic [THREAD_W-1:0] next_thread;
    logic                switch_request;
    logic [MASK_W-1:0]   ready_bits;
    logic                bad_delay;
  } out_t;

  // search unit status back to the controller
  typedef struct packed {
    logic                done;
    logic [THREAD_W-1:0] pick;
  } srch_t;

endpackage

### rtl/rrts_tmem.sv
// ----------------------------------------------------------------------------
// rrts_tmem
// Per-thread timeout memory: one write port, one registered read port.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module rrts_tmem #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [rrts_pkg::TICK_W-1:0] wr_data,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [rrts_pkg::TICK_W-1:0] rd_data
);
  import rrts_pkg::*;

  logic [TICK_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

endmodule

### rtl/rrts_search.sv
// ----------------------------------------------------------------------------
// rrts_search
// Round-robin search over the live ready mask, one candidate per cycle,
// starting after the current thread and wrapping at n.
// ----------------------------------------------------------------------------
module rrts_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rrts_pkg::MASK_W-1:0]   live,
  input  logic [rrts_pkg::THREAD_W-1:0] n,
  input  logic [rrts_pkg::THREAD_W-1:0] cur,
  output rrts_pkg::srch_t             status
);
  import rrts_pkg::*;

  logic                busy;
  logic                done;
  logic [THREAD_W-1:0] pick;
  logic [MASK_W-1:0]   live_r;
  logic [THREAD_W-1:0] n_r;
  logic [THREAD_W-1:0] cand;
  logic [THREAD_W-1:0] cnt;
  logic [THREAD_W-1:0] cand_inc;
  logic [THREAD_W-1:0] step;
  logic [THREAD_W-1:0] step_m1;
  logic                hit;
  logic                last;

  always_comb begin
    cand_inc = cand + 6'd1;
    step     = (cand_inc > n_r) ? 6'd1 : cand_inc;
    step_m1  = step - 6'd1;
    hit      = live_r[step_m1[4:0]];
    last     = (live_r == '0) || ((cnt + 6'd1) >= n_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        live_r <= live;
        n_r    <= n;
        cand   <= cur;
        cnt    <= '0;
      end else if (busy) begin
        if (hit || last) begin
          busy <= 1'b0;
          done <= 1'b1;
          pick <= hit ? step : '0;
        end else begin
          cand <= step;
          cnt  <= cnt + 6'd1;
        end
      end
    end
  end

  assign status.done = done;
  assign status.pick = pick;

endmodule

### rtl/round_robin_thread_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_top
// Round-robin thread scheduler with a ready bitmask and per-thread timeouts.
// ----------------------------------------------------------------------------
// One word in, one word out, one at a time. Thread 0 is idle; threads 1..n are
// user threads, n = min(user_threads, MAX_THREADS). Timeouts live in a
// one-port-read synchronous memory with per-entry written bits, so no clearing
// pass runs after reset. A tick walks the memory one entry per cycle. Start,
// delay and schedule run the round-robin search one candidate per cycle; a
// delay from the idle thread skips the search and is flagged as bad. The output
// register lets a finished result wait while the next word is accepted.
module round_robin_thread_scheduler_top #(
  parameter int MAX_THREADS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rrts_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rrts_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [rrts_pkg::THREAD_W-1:0] cfg_wdata
);
  import rrts_pkg::*;

  localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_SCHED  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]          state;
  logic [THREAD_W-1:0] user_threads;
  logic [MASK_W-1:0]   ready_mask;
  logic [THREAD_W-1:0] current;
  logic [THREAD_W-1:0] running;
  logic                sw;
  logic                bad;
  logic [THREAD_W-1:0] rd_cnt;
  logic                wb_valid;
  logic [IDX_W-1:0]    wb_addr;

  logic [THREAD_W-1:0] n;
  logic [MASK_W-1:0]   vmask;
  logic                accept;
  logic                load_out;
  logic [THREAD_W-1:0] cur_m1;
  logic [IDX_W-1:0]    rd_addr;
  logic [TICK_W-1:0]   rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [TICK_W-1:0]   wr_data;
  logic [4:0]          wb_bit;
  srch_t               srch;

  always_comb begin
    n = (user_threads > THREAD_W'(MAX_THREADS)) ? THREAD_W'(MAX_THREADS) : user_threads;
    for (int i = 0; i < MASK_W; i++) begin
      vmask[i] = (THREAD_W'(i) < n);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_EMIT) && (!out_valid || out_ready);
  assign cur_m1   = current - 6'd1;
  assign rd_addr  = rd_cnt[IDX_W-1:0];
  assign wb_bit   = 5'(wb_addr);

  // delay write and tick write-back never share a cycle
  always_comb begin
    wr_en   = (accept && in_data.action == ACT_DELAY && current != '0)
              || (wb_valid && rd_data != '0);
    wr_addr = wb_valid ? wb_addr : cur_m1[IDX_W-1:0];
    wr_data = wb_valid ? (rd_data - 32'd1) : in_data.ticks;
  end

  rrts_tmem #(
    .DEPTH (MAX_THREADS),
    .IDX_W (IDX_W)
  ) u_tmem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrts_search u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_LAUNCH),
    .live   (ready_mask & vmask),
    .n      (n),
    .cur    (current),
    .status (srch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      user_threads <= '0;
    end else if (cfg_we) begin
      user_threads <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ready_mask <= '0;
      current    <= '0;
      running    <= '0;
      sw         <= 1'b0;
      bad        <= 1'b0;
      rd_cnt     <= '0;
      wb_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            sw <= 1'b0;
            bad <= 1'b0;
            case (in_data.action)
              ACT_START: begin
                ready_mask <= vmask;
                state      <= S_LAUNCH;
              end
              ACT_TICK: begin
                rd_cnt   <= '0;
                wb_valid <= 1'b0;
                state    <= S_TICK;
              end
              ACT_DELAY: begin
                if (current == '0) begin
                  bad   <= 1'b1;
                  state <= S_EMIT;
                end else begin
                  ready_mask[cur_m1[4:0]] <= 1'b0;
                  state                   <= S_LAUNCH;
                end
              end
              default: begin
                state <= S_LAUNCH;
              end
            endcase
          end
        end
        S_TICK: begin
          if (wb_valid && rd_data == 32'd1) begin
            ready_mask[wb_bit] <= 1'b1;
          end
          if (rd_cnt < n) begin
            rd_cnt   <= rd_cnt + 6'd1;
            wb_valid <= 1'b1;
            wb_addr  <= rd_addr;
          end else begin
            wb_valid <= 1'b0;
            if (!wb_valid) begin
              state <= S_EMIT;
            end
          end
        end
        S_LAUNCH: begin
          state <= S_SCHED;
        end
        S_SCHED: begin
          if (srch.done) begin
            current <= srch.pick;
            running <= srch.pick;
            sw      <= (srch.pick != running);
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.next_thread    <= current;
      out_data.switch_request <= sw;
      out_data.ready_bits     <= ready_mask;
      out_data.bad_delay      <= bad;
    end
  end

endmodule

### rtl/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "round_robin_thread_scheduler_top_assert.svh"

module rrts_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input rrts_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input rrts_pkg::out_t out_data
);
  import rrts_pkg::*;

  // a rejected delay never schedules
  `RRTS_ASSERT(a_bad_no_switch, out_valid && out_data.bad_delay |-> !out_data.switch_request, "bad delay with switch request")
  `RRTS_ASSERT(a_bad_from_idle, out_valid && out_data.bad_delay |-> out_data.next_thread == '0, "bad delay while a user thread is current")
  // one word in flight at a time
  `RRTS_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "input taken on consecutive cycles")
  `RRTS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled output word changed")

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (.*);
